/* hw/rtl/multiset_bag_table_macros.svh */
// ---------------------------------------------------------------------------
// multiset_bag_table assertion macros
// shared forms for the concurrent checks on the bag table ports
// ---------------------------------------------------------------------------
`ifndef MULTISET_BAG_TABLE_MACROS_SVH
`define MULTISET_BAG_TABLE_MACROS_SVH

// check that is switched off while reset is held
`define MBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds across reset
`define MBT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mbt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_pkg
// shared sizes, types and request codes of the multiset bag table
// ---------------------------------------------------------------------------
package mbt_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int REQ_W      = 3;
  localparam int OUT_CNT_W  = 7;

  localparam logic [6:0] MAX_ITEMS_RST = 7'd64;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // control from the sequencer to the row of cells
  typedef struct packed {
    logic  shift;
    item_t tail;
  } chain_ctl_t;

  function automatic logic [OUT_CNT_W-1:0] sat_cnt(input cnt_t v);
    if (32'(v) > 127) begin
      return 7'd127;
    end
    return OUT_CNT_W'(v);
  endfunction

endpackage

/* hw/rtl/multiset_bag_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiset_bag_table
// unordered multiset of words held in a rotating row of entry cells
// ---------------------------------------------------------------------------
// requests arrive on the in_ stream: tuser carries the request kind (add,
// remove, replace, query, clear), tdata the key and the value. each request
// gives exactly one result on the out_ stream: tuser is the ok flag, tdata
// the copy count of the key (query only) and the size after the request.
// cfg_wen with cfg_wdata sets the add limit; write it only while idle.
// add, remove, replace and query rotate the whole ring of 64 cells once,
// one cell per cycle, then take a fix-up step; the result follows in the
// done step. clear, unknown kinds and an add without room go straight from
// acceptance to the done step.
// one request is in work at a time; in_tready is high only between requests.
// the result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the sequencer in its done step once a
// further result is ready. reset empties the bag and sets the limit to 64.
// ---------------------------------------------------------------------------
module multiset_bag_table
  import mbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key[31:0], value[63:32]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // frequency[6:0], size[13:7], zero[15:14]
  output logic [0:0]  out_tuser,  // ok[0]
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata
);

  logic [6:0]           max_items_r;
  item_t                head;
  chain_ctl_t           ctl;
  logic                 res_ok;
  logic [OUT_CNT_W-1:0] res_freq;
  logic [OUT_CNT_W-1:0] res_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_items_r <= MAX_ITEMS_RST;
    end else if (cfg_wen) begin
      max_items_r <= cfg_wdata;
    end
  end

  mbt_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  mbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req       (in_tuser),
    .key       (ITEM_WIDTH'(in_tdata[31:0])),
    .value     (ITEM_WIDTH'(in_tdata[63:32])),
    .max_items (max_items_r),
    .head      (head),
    .ctl       (ctl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ok    (res_ok),
    .out_freq  (res_freq),
    .out_size  (res_size)
  );

  assign out_tdata = {2'b00, res_size, res_freq};
  assign out_tuser = res_ok;

endmodule

/* hw/rtl/mbt_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_cell
// one entry of the bag, loads its neighbour's entry on a shift
// ---------------------------------------------------------------------------
module mbt_cell
  import mbt_pkg::*;
(
  input  logic  clk,
  input  logic  shift,
  input  item_t d,
  output item_t q
);

  item_t entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= d;
    end
  end

  assign q = entry_r;

endmodule

/* hw/rtl/mbt_chain.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_chain
// ring of entry cells: head at cell 0, new data enters at the last cell
// ---------------------------------------------------------------------------
module mbt_chain
  import mbt_pkg::*;
(
  input  logic       clk,
  input  chain_ctl_t ctl,
  output item_t      head
);

  item_t q [CAPACITY];

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    item_t d;
    if (j == CAPACITY - 1) begin : g_tail
      assign d = ctl.tail;
    end else begin : g_mid
      assign d = q[j+1];
    end
    mbt_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (d),
      .q     (q[j])
    );
  end

  assign head = q[0];

endmodule

/* hw/rtl/mbt_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_ctrl
// request sequencer: rotates the ring once for each scanning request and holds the result
// ---------------------------------------------------------------------------
module mbt_ctrl
  import mbt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req,
  input  item_t                key,
  input  item_t                value,
  input  logic [6:0]           max_items,
  input  item_t                head,
  output chain_ctl_t           ctl,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_ok,
  output logic [OUT_CNT_W-1:0] out_freq,
  output logic [OUT_CNT_W-1:0] out_size
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIX, ST_DONE} state_t;

  state_t               state_r;
  logic [REQ_W-1:0]     op_r;
  item_t                key_r;
  item_t                val_r;
  item_t                first_r;
  cnt_t                 step_r;
  cnt_t                 count_r;
  cnt_t                 freq_r;
  logic                 found_r;
  logic                 ok_r;
  logic                 out_valid_r;
  logic                 out_ok_r;
  logic [OUT_CNT_W-1:0] out_freq_r;
  logic [OUT_CNT_W-1:0] out_size_r;

  logic live;
  logic match;
  logic add_room;
  logic last_step;
  logic res_load;

  assign live      = step_r < count_r;
  assign match     = live && (head == key_r);
  assign last_step = step_r == CNT_W'(CAPACITY - 1);
  assign add_room  = (32'(count_r) < 32'(max_items)) && (32'(count_r) < CAPACITY);
  // result register free or being emptied this cycle
  assign res_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // step i of the scan sees logical entry i at the head
  always_comb begin
    ctl.shift = 1'b0;
    ctl.tail  = head;
    unique case (state_r)
      ST_SCAN: begin
        ctl.shift = 1'b1;
        case (op_r)
          REQ_ADD: begin
            if (step_r == count_r) ctl.tail = val_r;
          end
          REQ_REPLACE: begin
            if (match && !found_r) ctl.tail = val_r;
          end
          REQ_REMOVE: begin
            // hole filled by entry 0, which is then dropped by one extra shift
            if (match && !found_r && step_r != '0) ctl.tail = first_r;
          end
          default: ;
        endcase
      end
      ST_FIX: begin
        ctl.shift = (op_r == REQ_REMOVE) && found_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= req;
            key_r   <= key;
            val_r   <= value;
            step_r  <= '0;
            found_r <= 1'b0;
            freq_r  <= '0;
            case (req) inside
              REQ_ADD: begin
                ok_r    <= 1'b0;
                state_r <= add_room ? ST_SCAN : ST_DONE;
              end
              REQ_REMOVE, REQ_REPLACE, REQ_QUERY: begin
                state_r <= ST_SCAN;
              end
              REQ_CLEAR: begin
                count_r <= '0;
                ok_r    <= 1'b1;
                state_r <= ST_DONE;
              end
              default: begin
                ok_r    <= 1'b0;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          step_r  <= CNT_W'(step_r + 1'b1);
          found_r <= found_r | match;
          if (op_r == REQ_QUERY && match) freq_r <= CNT_W'(freq_r + 1'b1);
          if (step_r == '0) first_r <= head;
          if (last_step) state_r <= ST_FIX;
        end
        ST_FIX: begin
          case (op_r)
            REQ_ADD: begin
              count_r <= CNT_W'(count_r + 1'b1);
              ok_r    <= 1'b1;
            end
            REQ_REMOVE: begin
              if (found_r) count_r <= CNT_W'(count_r - 1'b1);
              ok_r <= found_r;
            end
            REQ_REPLACE: ok_r <= found_r;
            REQ_QUERY:   ok_r <= freq_r != '0;
            default:     ok_r <= 1'b0;
          endcase
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (res_load) begin
            out_ok_r    <= ok_r;
            out_freq_r  <= sat_cnt(freq_r);
            out_size_r  <= sat_cnt(count_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_freq  = out_freq_r;
  assign out_size  = out_size_r;

endmodule

/* hw/rtl/mbt_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_checker
// port-level checks of the bag table, bound to the top level
// ---------------------------------------------------------------------------
`include "multiset_bag_table_macros.svh"

module mbt_checker
  import mbt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic out_stall;

  assign out_stall = out_tvalid && !out_tready;

  // a stalled result holds
  `MBT_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable({out_tuser, out_tdata}), "result changed while stalled")

  // one request in work at a time
  `MBT_ASSERT(a_busy_after_req, in_tvalid && in_tready |=> !in_tready, "request taken while busy")

  // no copy count above the size
  `MBT_ASSERT(a_freq_le_size, out_tvalid |-> out_tdata[6:0] <= out_tdata[13:7], "frequency above size")

  // size never beyond the store
  `MBT_ASSERT(a_size_cap, out_tvalid |-> 32'(out_tdata[13:7]) <= CAPACITY, "size beyond capacity")

  `MBT_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind multiset_bag_table mbt_checker u_mbt_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the multiset bag table: a shadow bag predicts the
// reply to every accepted request, and each reply is compared field by field
// under several add limits and idling patterns on both streams
// ---------------------------------------------------------------------------
module tb;
  import mbt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_CLEAR + 3'd1;
  localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = '1;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 70;
  localparam int RANDOM_ITEMS = 135;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    item_t            key;
    item_t            value;
  } bag_req_t;

  typedef struct packed {
    logic                 ok;
    logic [OUT_CNT_W-1:0] freq;
    logic [OUT_CNT_W-1:0] size;
  } bag_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // key[31:0], value[63:32]
  logic [2:0]  in_tuser = '0;   // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // frequency[6:0], size[13:7], zero[15:14]
  logic [0:0]  out_tuser;       // ok[0]
  logic        cfg_wen = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  // shadow copy of the bag
  item_t      shadow_words[CAPACITY];
  int         shadow_count = 0;
  int         add_limit = int'(MAX_ITEMS_RST);

  bag_req_t   requests_todo[$];
  bag_reply_t replies_due[$];
  item_t      word_pool[8];
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;

  multiset_bag_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bag_reply_t bag_apply(bag_req_t r);
    bag_reply_t res;
    int         first_hit;
    int         hits;
    int         room;
    res       = '0;
    hits      = 0;
    first_hit = shadow_count;
    room      = (add_limit < CAPACITY) ? add_limit : CAPACITY;
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_words[i] == r.key) begin
        if (hits == 0) begin
          first_hit = i;
        end
        hits++;
      end
    end
    case (r.kind)
      REQ_ADD: begin
        if (shadow_count < room) begin
          shadow_words[shadow_count] = r.value;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        // last entry fills the hole
        if (first_hit < shadow_count) begin
          shadow_count--;
          shadow_words[first_hit] = shadow_words[shadow_count];
          res.ok = 1'b1;
        end
      end
      REQ_REPLACE: begin
        if (first_hit < shadow_count) begin
          shadow_words[first_hit] = r.value;
          res.ok = 1'b1;
        end
      end
      REQ_QUERY: begin
        res.freq = OUT_CNT_W'(hits);
        res.ok   = (hits > 0);
      end
      REQ_CLEAR: begin
        shadow_count = 0;
        res.ok       = 1'b1;
      end
      default: begin
      end
    endcase
    res.size = OUT_CNT_W'(shadow_count);
    return res;
  endfunction

  always @(posedge clk) begin : drive_requests
    bag_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        replies_due.insert(replies_due.size(),
                           bag_apply({in_tuser, in_tdata[31:0], in_tdata[63:32]}));
      end
      if (!in_tvalid || in_tready) begin
        if (requests_todo.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = requests_todo.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.kind;
          in_tdata  <= {nxt.value, nxt.key};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_replies
    bag_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding");
          mismatch_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_tuser[0] !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_tuser[0]);
            mismatch_count++;
          end
          if (out_tdata[6:0] !== want.freq) begin
            $error("frequency: expected %0d, got %0d", want.freq, out_tdata[6:0]);
            mismatch_count++;
          end
          if (out_tdata[13:7] !== want.size) begin
            $error("size: expected %0d, got %0d", want.size, out_tdata[13:7]);
            mismatch_count++;
          end
          if (out_tdata[15:14] !== 2'b00) begin
            $error("pad: expected 0, got %0d", out_tdata[15:14]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ends the run when neither stream moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_req(input logic [REQ_W-1:0] kind, input item_t key, input item_t value);
    requests_todo.insert(requests_todo.size(),
                         bag_req_t'{kind: kind, key: key, value: value});
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (requests_todo.size() != 0 || in_tvalid || replies_due.size() != 0);
  endtask

  task automatic set_limit(input logic [6:0] lim);
    wait_idle();
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= lim;
    add_limit = int'(lim);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  function automatic item_t pick_word();
    if ($urandom_range(3) != 0) begin
      return word_pool[$urandom_range(7)];
    end
    return $urandom;
  endfunction

  // fill phases favour adds and never clear, so the bag reaches its limit
  task automatic push_random(input int add_pct, input bit allow_clear);
    int r;
    logic [REQ_W-1:0] kind;
    r = $urandom_range(99);
    if (r < add_pct) begin
      kind = REQ_ADD;
    end else begin
      r = $urandom_range(99);
      if (r < 30) begin
        kind = REQ_REMOVE;
      end else if (r < 50) begin
        kind = REQ_REPLACE;
      end else if (r < 85) begin
        kind = REQ_QUERY;
      end else if (r < 93) begin
        kind = 3'($urandom_range(REQ_LAST_UNUSED, REQ_FIRST_UNUSED));
      end else begin
        kind = allow_clear ? REQ_CLEAR : REQ_QUERY;
      end
    end
    push_req(kind, pick_word(), pick_word());
  endtask

  initial begin : stimulus
    logic [6:0] limits[8];
    int         idle_modes[4][2];
    limits     = '{7'd127, 7'd64, 7'd0, 7'd5, 7'd64, 7'd1, 7'd100, 7'd64};
    idle_modes = '{'{0, 0}, '{81, 0}, '{0, 81}, '{26, 26}};
    word_pool  = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                   $urandom, $urandom, $urandom, $urandom};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty bag, duplicates, swap-in on remove, unused kinds, clear
    push_req(REQ_QUERY,   32'h0,         32'h0);
    push_req(REQ_REMOVE,  32'h0,         32'h0);
    push_req(REQ_REPLACE, 32'h0,         32'h1);
    push_req(REQ_ADD,     32'hFFFF_FFFF, 32'h0);
    push_req(REQ_ADD,     32'h0,         32'hFFFF_FFFF);
    push_req(REQ_ADD,     32'hFFFF_FFFF, 32'h0);
    push_req(REQ_QUERY,   32'h0,         32'hFFFF_FFFF);
    push_req(REQ_QUERY,   32'hFFFF_FFFF, 32'h0);
    push_req(REQ_QUERY,   32'h1234_5678, 32'h0);
    push_req(REQ_REPLACE, 32'h0,         32'hAAAA_AAAA);
    push_req(REQ_QUERY,   32'h0,         32'h0);
    push_req(REQ_REMOVE,  32'h0,         32'h0);
    push_req(REQ_REMOVE,  32'hFFFF_FFFF, 32'h0);
    push_req(REQ_FIRST_UNUSED,        32'hAAAA_AAAA, 32'h5555_5555);
    push_req(REQ_FIRST_UNUSED + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_LAST_UNUSED,         32'h0,         32'h0);
    push_req(REQ_CLEAR,   32'hAAAA_AAAA, 32'h0);
    push_req(REQ_QUERY,   32'hAAAA_AAAA, 32'h0);

    // limit reached, then lowered below the count
    set_limit(7'd2);
    push_req(REQ_ADD, 32'h0, 32'h1);
    push_req(REQ_ADD, 32'h0, 32'h2);
    push_req(REQ_ADD, 32'h0, 32'h3);
    set_limit(7'd1);
    push_req(REQ_ADD,     32'h0, 32'h4);
    push_req(REQ_QUERY,   32'h2, 32'h0);
    push_req(REQ_REPLACE, 32'h1, 32'h2);
    push_req(REQ_REMOVE,  32'h2, 32'h0);
    set_limit(7'd0);
    push_req(REQ_ADD, 32'h0, 32'h5);

    for (int p = 0; p < 8; p++) begin
      set_limit(limits[p]);
      sender_idle_pct    = idle_modes[p % 4][0];
      receiver_stall_pct = idle_modes[p % 4][1];
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (p % 2 == 0) begin
          push_random(65, 1'b0);
        end else begin
          push_random(40, 1'b1);
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_cell.sv
hw/rtl/mbt_chain.sv
hw/rtl/mbt_ctrl.sv
hw/rtl/multiset_bag_table.sv
hw/rtl/mbt_checker.sv
tb/tb.sv
